// ===== sv/running_mean_variance_unit_assert.svh =====
// Assertion macros for the running mean and variance block.
// Used by the port checker; expects signals clk and rst_n in the using scope.
`ifndef RUNNING_MEAN_VARIANCE_UNIT_ASSERT_SVH
`define RUNNING_MEAN_VARIANCE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RMV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RMV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rmv_pkg.sv =====
// Package for the running mean and variance block: widths, codes and types.
// Used by every RTL file of the block; depends on nothing.
`default_nettype none

package rmv_pkg;

    // Field widths and fixed-point formats.
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 16;
    localparam int MEAN_BITS   = SAMPLE_BITS + FRAC_BITS;
    localparam int COUNT_BITS  = 32;
    localparam int M2_BITS     = 64;
    localparam int M2_FRAC     = 8;
    localparam int VAR_BITS    = 56;

    // Product of two deviations and its alignment to the m2 format.
    localparam int PROD_BITS  = 2 * MEAN_BITS;
    localparam int PROD_SHIFT = 2 * FRAC_BITS - M2_FRAC;

    // Shared multiply/divide unit sizing.
    localparam int OPB_BITS  = (MEAN_BITS > COUNT_BITS) ? MEAN_BITS : COUNT_BITS;
    localparam int ADD_BITS  = OPB_BITS + 1;
    localparam int LO_BITS   = (M2_BITS > MEAN_BITS) ? M2_BITS : MEAN_BITS;
    localparam int ITER_BITS = $clog2(LO_BITS + 1);

    // Operation of the shared unit.
    typedef enum logic {
        OP_MUL,
        OP_DIV
    } op_t;

    // Job the sequencer hands to the shared unit.
    typedef enum logic [1:0] {
        JOB_MEAN_DIV,
        JOB_SQ_MUL,
        JOB_VAR_DIV
    } job_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MEAN_DIV,
        ST_MEAN_WAIT,
        ST_MEAN_UPD,
        ST_MUL,
        ST_MUL_WAIT,
        ST_ACC,
        ST_VAR_DIV,
        ST_VAR_WAIT,
        ST_OUT
    } state_t;

    // Controls from the sequencer to the datapath.
    typedef struct packed {
        logic in_ready;
        logic unit_start;
        job_t job;
        logic ld_diff;
        logic ld_mean;
        logic ld_m2;
        logic ld_out;
    } ctrl_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic in_fire;
        logic unit_done;
        logic var_ok;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== sv/rmv_if.sv =====
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on rmv_pkg for the payload widths.
`default_nettype none

// Sample channel: one unsigned sample per beat.
interface rmv_sample_if import rmv_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink (input valid, input sample_value, output ready);
endinterface

// Result channel: count, mean and variance per beat.
interface rmv_result_if import rmv_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] sample_count;
    logic [MEAN_BITS-1:0]  mean_q16;
    logic [VAR_BITS-1:0]   variance_q8;
    logic                  variance_valid;

    modport source (output valid, output sample_count, output mean_q16,
                    output variance_q8, output variance_valid, input ready);
    modport sink (input valid, input sample_count, input mean_q16,
                  input variance_q8, input variance_valid, output ready);
endinterface

`default_nettype wire

// ===== sv/running_mean_variance_unit.sv =====
// Top level of the running mean and variance block (Welford update, fixed point).
// Depends on rmv_pkg, rmv_if, rmv_muldiv and rmv_ctrl.
`default_nettype none

// Each sample beat updates the count, the Q24.16 running mean and the sum of
// squared deviations, and returns one result beat with the count, the mean
// and the sample variance m2/(count-1) with 8 fraction bits (0 and
// variance_valid low until two samples are in). The block takes one sample
// at a time: the division of the deviation by the count, the deviation
// product and the division of m2 by count-1 all run bit-serially on one
// shared add/subtract unit, so ready stays low from acceptance until the
// result is loaded, and the first sample skips the division of m2. A
// finished result waits in an output register, so the next sample is
// accepted while it is still unread.
module running_mean_variance_unit import rmv_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    rmv_sample_if.sink   samples,
    rmv_result_if.source results
);

    ctrl_t ctrl;
    stat_t stat;

    // Architectural state.
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [MEAN_BITS-1:0]  mean_reg;
    logic [MEAN_BITS-1:0]  mean_next;
    logic [M2_BITS-1:0]    m2_reg;
    logic [M2_BITS-1:0]    m2_next;

    // Working registers of one sample.
    logic [SAMPLE_BITS-1:0] x_reg;
    logic [MEAN_BITS-1:0]   d1_reg;
    logic [MEAN_BITS-1:0]   d1_next;
    logic                   up_reg;
    logic                   up_next;
    logic [MEAN_BITS-1:0]   d2_reg;
    logic [MEAN_BITS-1:0]   d2_next;

    // Output register.
    logic                  out_valid_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic [MEAN_BITS-1:0]  out_mean_reg;
    logic [VAR_BITS-1:0]   out_var_reg;
    logic [VAR_BITS-1:0]   out_var_next;
    logic                  out_vvalid_reg;

    // Shared unit connections.
    op_t                  unit_op;
    logic [LO_BITS-1:0]   unit_a;
    logic [OPB_BITS-1:0]  unit_b;
    logic [ITER_BITS-1:0] unit_n;
    logic [ADD_BITS-1:0]  unit_hi;
    logic [LO_BITS-1:0]   unit_lo;
    logic                 unit_done;

    logic                 in_fire;
    logic                 var_ok;
    logic [MEAN_BITS-1:0] xq;
    logic [MEAN_BITS:0]   diff;
    logic [MEAN_BITS-1:0] step;
    logic [PROD_BITS-1:0] prod;
    logic [PROD_BITS+M2_BITS-1:0] prod_ext;
    logic [M2_BITS-1:0]   inc;
    logic [M2_BITS:0]     m2_sum;
    logic [M2_BITS-1:0]   quot;

    rmv_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    rmv_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ctrl.unit_start),
        .op     (unit_op),
        .a      (unit_a),
        .b      (unit_b),
        .n_iter (unit_n),
        .hi     (unit_hi),
        .lo     (unit_lo),
        .done   (unit_done)
    );

    // Handshake and status.
    assign samples.ready = ctrl.in_ready;
    assign in_fire       = samples.valid && ctrl.in_ready;
    assign var_ok        = (count_reg > COUNT_BITS'(1));

    always_comb
    begin
        stat.in_fire   = in_fire;
        stat.unit_done = unit_done;
        stat.var_ok    = var_ok;
        stat.out_free  = !out_valid_reg || results.ready;
    end

    // Operands for the shared unit; dividends are left-aligned in the low word.
    always_comb
    begin
        case (ctrl.job)
            JOB_MEAN_DIV:
            begin
                unit_op = OP_DIV;
                unit_a  = LO_BITS'(d1_reg) << (LO_BITS - MEAN_BITS);
                unit_b  = OPB_BITS'(count_reg);
                unit_n  = ITER_BITS'(MEAN_BITS);
            end
            JOB_SQ_MUL:
            begin
                unit_op = OP_MUL;
                unit_a  = LO_BITS'(d2_reg);
                unit_b  = OPB_BITS'(d1_reg);
                unit_n  = ITER_BITS'(MEAN_BITS);
            end
            JOB_VAR_DIV:
            begin
                unit_op = OP_DIV;
                unit_a  = LO_BITS'(m2_reg) << (LO_BITS - M2_BITS);
                unit_b  = OPB_BITS'(count_reg - COUNT_BITS'(1));
                unit_n  = ITER_BITS'(M2_BITS);
            end
            default:
            begin
                unit_op = OP_MUL;
                unit_a  = '0;
                unit_b  = '0;
                unit_n  = '0;
            end
        endcase
    end

    // Deviation of the scaled sample from the old mean, as sign and magnitude.
    always_comb
    begin
        xq      = MEAN_BITS'(x_reg) << FRAC_BITS;
        diff    = {1'b0, xq} - {1'b0, mean_reg};
        up_next = !diff[MEAN_BITS];
        d1_next = up_next ? diff[MEAN_BITS-1:0] : (mean_reg - xq);
    end

    // Mean moves toward the sample by the truncated quotient.
    always_comb
    begin
        step      = unit_lo[MEAN_BITS-1:0];
        mean_next = up_reg ? (mean_reg + step) : (mean_reg - step);
        d2_next   = d1_reg - step;
    end

    // Product of the deviations, aligned to m2 and added with saturation.
    always_comb
    begin
        prod     = {unit_hi[MEAN_BITS-1:0], unit_lo[LO_BITS-1 -: MEAN_BITS]};
        prod_ext = (PROD_BITS + M2_BITS)'(prod) >> PROD_SHIFT;
        inc      = (|prod_ext[PROD_BITS+M2_BITS-1:M2_BITS]) ? '1
                                                            : prod_ext[M2_BITS-1:0];
        m2_sum   = {1'b0, m2_reg} + {1'b0, inc};
        m2_next  = m2_sum[M2_BITS] ? '1 : m2_sum[M2_BITS-1:0];
    end

    // Variance from the quotient, clamped to the output width, or zero without var_ok.
    always_comb
    begin
        quot = unit_lo[M2_BITS-1:0];
        if (!var_ok)
        begin
            out_var_next = '0;
        end
        else if (|quot[M2_BITS-1:VAR_BITS])
        begin
            out_var_next = '1;
        end
        else
        begin
            out_var_next = quot[VAR_BITS-1:0];
        end
    end

    assign count_next = (count_reg == '1) ? count_reg : (count_reg + COUNT_BITS'(1));

    // Count, mean, m2 and the result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            mean_reg      <= '0;
            m2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                count_reg <= count_next;
            end
            if (ctrl.ld_mean)
            begin
                mean_reg <= mean_next;
            end
            if (ctrl.ld_m2)
            begin
                m2_reg <= m2_next;
            end
            if (ctrl.ld_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Per-sample payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg <= samples.sample_value;
        end
        if (ctrl.ld_diff)
        begin
            d1_reg <= d1_next;
            up_reg <= up_next;
        end
        if (ctrl.ld_mean)
        begin
            d2_reg <= d2_next;
        end
        if (ctrl.ld_out)
        begin
            out_count_reg  <= count_reg;
            out_mean_reg   <= mean_reg;
            out_var_reg    <= out_var_next;
            out_vvalid_reg <= var_ok;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.sample_count   = out_count_reg;
    assign results.mean_q16       = out_mean_reg;
    assign results.variance_q8    = out_var_reg;
    assign results.variance_valid = out_vvalid_reg;

endmodule

`default_nettype wire

// ===== sv/rmv_muldiv.sv =====
// Shared iterative unit: shift-add multiply or restoring divide, one bit a cycle.
// Depends on rmv_pkg for widths and the operation code.
`default_nettype none

module rmv_muldiv import rmv_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire op_t                  op,
    input  wire logic [LO_BITS-1:0]   a,
    input  wire logic [OPB_BITS-1:0]  b,
    input  wire logic [ITER_BITS-1:0] n_iter,
    output logic [ADD_BITS-1:0]       hi,
    output logic [LO_BITS-1:0]        lo,
    output logic                      done
);

    logic                 busy_reg;
    logic [ITER_BITS-1:0] cnt_reg;
    logic                 done_reg;
    op_t                  op_reg;
    logic [ADD_BITS-1:0]  hi_reg;
    logic [ADD_BITS-1:0]  hi_next;
    logic [LO_BITS-1:0]   lo_reg;
    logic [LO_BITS-1:0]   lo_next;
    logic [OPB_BITS-1:0]  b_reg;

    logic                 is_div;
    logic [ADD_BITS-1:0]  rem_shift;
    logic [ADD_BITS-1:0]  x_op;
    logic [ADD_BITS-1:0]  y_op;
    logic [ADD_BITS:0]    sum;
    logic                 qbit;

    // One step: the single adder either accumulates the multiplicand or
    // trial-subtracts the divisor from the shifted remainder.
    always_comb
    begin
        is_div    = (op_reg == OP_DIV);
        rem_shift = {hi_reg[ADD_BITS-2:0], lo_reg[LO_BITS-1]};
        x_op      = is_div ? rem_shift : hi_reg;
        y_op      = (is_div || lo_reg[0]) ? {1'b0, b_reg} : '0;
        sum       = {1'b0, x_op} + {1'b0, (is_div ? ~y_op : y_op)}
                    + (ADD_BITS + 1)'(is_div);
        qbit      = sum[ADD_BITS];
        if (is_div)
        begin
            hi_next = qbit ? sum[ADD_BITS-1:0] : rem_shift;
            lo_next = {lo_reg[LO_BITS-2:0], qbit};
        end
        else
        begin
            hi_next = sum[ADD_BITS:1];
            lo_next = {sum[0], lo_reg[LO_BITS-1:1]};
        end
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= n_iter;
                op_reg   <= op;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - ITER_BITS'(1);
                if (cnt_reg == ITER_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg <= '0;
            lo_reg <= a;
            b_reg  <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign hi   = hi_reg;
    assign lo   = lo_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== sv/rmv_ctrl.sv =====
// Sequencer of the running mean and variance block.
// Depends on rmv_pkg for the state, job, control and status types.
`default_nettype none

module rmv_ctrl import rmv_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire stat_t stat,
    output ctrl_t      ctrl
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and controls.
    always_comb
    begin
        state_next      = state_reg;
        ctrl            = '0;
        ctrl.job        = JOB_MEAN_DIV;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (stat.in_fire)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                ctrl.ld_diff = 1'b1;
                state_next   = ST_MEAN_DIV;
            end
            ST_MEAN_DIV:
            begin
                ctrl.unit_start = 1'b1;
                ctrl.job        = JOB_MEAN_DIV;
                state_next      = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (stat.unit_done)
                begin
                    state_next = ST_MEAN_UPD;
                end
            end
            ST_MEAN_UPD:
            begin
                ctrl.ld_mean = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                ctrl.unit_start = 1'b1;
                ctrl.job        = JOB_SQ_MUL;
                state_next      = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (stat.unit_done)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                ctrl.ld_m2 = 1'b1;
                state_next = stat.var_ok ? ST_VAR_DIV : ST_OUT;
            end
            ST_VAR_DIV:
            begin
                ctrl.unit_start = 1'b1;
                ctrl.job        = JOB_VAR_DIV;
                state_next      = ST_VAR_WAIT;
            end
            ST_VAR_WAIT:
            begin
                if (stat.unit_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    ctrl.ld_out = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/running_mean_variance_unit_chk.sv =====
// Port checker for the running mean and variance block, bound to the top level.
// Depends on rmv_pkg and the macros in running_mean_variance_unit_assert.svh.
`default_nettype none

`include "running_mean_variance_unit_assert.svh"

module running_mean_variance_unit_chk import rmv_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [COUNT_BITS-1:0] sample_count,
    input wire logic [MEAN_BITS-1:0]  mean_q16,
    input wire logic [VAR_BITS-1:0]   variance_q8,
    input wire logic                  variance_valid
);

    // A stalled result beat keeps all of its fields.
    `RMV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_count) && $stable(mean_q16) && $stable(variance_q8) && $stable(variance_valid), "result beat changed while stalled")

    // The block works on one sample at a time.
    `RMV_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "ready stayed high after a sample beat")

    // The variance flag follows the count.
    `RMV_ASSERT_SAME(a_valid_count, out_valid, variance_valid == (sample_count > COUNT_BITS'(1)), "variance flag disagrees with count")

    // An invalid variance reads as zero.
    `RMV_ASSERT_SAME(a_var_zero, out_valid && !variance_valid, variance_q8 == '0, "nonzero variance while flag is low")

endmodule

bind running_mean_variance_unit running_mean_variance_unit_chk u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (samples.valid),
    .in_ready       (samples.ready),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .sample_count   (results.sample_count),
    .mean_q16       (results.mean_q16),
    .variance_q8    (results.variance_q8),
    .variance_valid (results.variance_valid)
);

`default_nettype wire
